>>> rtl/sql_token_lexer_assert.svh
// Assertion macros shared by the lexer modules.
`ifndef SQL_TOKEN_LEXER_ASSERT_SVH
`define SQL_TOKEN_LEXER_ASSERT_SVH

`ifndef SYNTH
`define SQLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sql_token_lexer assertion failed");
`define SQLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sql_token_lexer assertion failed");
`else
`define SQLT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SQLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/sqlt_pkg.sv
package sqlt_pkg;

	localparam int KIND_W  = 5;
	localparam int START_W = 12;
	localparam int LEN_W   = 13;
	localparam int STAT_W  = 2;

	localparam logic [KIND_W-1:0] TK_EOF    = 5'd0;
	localparam logic [KIND_W-1:0] TK_IDENT  = 5'd1;
	localparam logic [KIND_W-1:0] TK_INT    = 5'd2;
	localparam logic [KIND_W-1:0] TK_STR    = 5'd3;
	localparam logic [KIND_W-1:0] TK_LPAREN = 5'd4;
	localparam logic [KIND_W-1:0] TK_RPAREN = 5'd5;
	localparam logic [KIND_W-1:0] TK_COMMA  = 5'd6;
	localparam logic [KIND_W-1:0] TK_STAR   = 5'd7;
	localparam logic [KIND_W-1:0] TK_SEMI   = 5'd8;
	localparam logic [KIND_W-1:0] TK_EQ     = 5'd9;
	localparam logic [KIND_W-1:0] TK_LT     = 5'd10;
	localparam logic [KIND_W-1:0] TK_GT     = 5'd11;
	localparam logic [KIND_W-1:0] TK_LE     = 5'd12;
	localparam logic [KIND_W-1:0] TK_GE     = 5'd13;
	localparam logic [KIND_W-1:0] TK_NE     = 5'd14;
	localparam logic [KIND_W-1:0] TK_KW0    = 5'd15;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_SYNTAX = 2'd1;
	localparam logic [STAT_W-1:0] ST_LONG   = 2'd2;

	localparam logic [START_W-1:0] START_MAX = 12'd4095;

	// Keyword text is left aligned and zero padded to six characters.
	localparam int KW_NUM    = 13;
	localparam int KW_MAXLEN = 6;
	localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_NUM] = '{
		"select", "insert", {"into", 16'h0}, "create", {"table", 8'h0},
		{"from", 16'h0}, {"where", 8'h0}, "values", {"null", 16'h0},
		{"not", 24'h0}, {"is", 32'h0}, {"and", 24'h0}, {"or", 32'h0}
	};
	localparam logic [2:0] KW_LEN [KW_NUM] = '{
		3'd6, 3'd6, 3'd4, 3'd6, 3'd5, 3'd4, 3'd5, 3'd6, 3'd4, 3'd3, 3'd2, 3'd3, 3'd2
	};

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic [3:0] {
		CC_SPACE, CC_ALPHA, CC_UNDER, CC_DIGIT, CC_QUOTE, CC_LPAREN, CC_RPAREN,
		CC_COMMA, CC_STAR, CC_SEMI, CC_EQ, CC_LT, CC_GT, CC_BANG, CC_OTHER
	} cclass_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic [STAT_W-1:0]  status;
	} result_t;

	// All results caused by one item; n counts the used slots, oldest in slot 0.
	typedef struct packed {
		logic [1:0]       n;
		result_t [2:0]    res;
	} bundle_t;

	function automatic cclass_t classify(input logic [7:0] c);
		cclass_t cc;
		unique case (c) inside
			[8'd9:8'd13], 8'd32: cc = CC_SPACE;
			["a":"z"], ["A":"Z"]: cc = CC_ALPHA;
			"_": cc = CC_UNDER;
			["0":"9"]: cc = CC_DIGIT;
			"'": cc = CC_QUOTE;
			"(": cc = CC_LPAREN;
			")": cc = CC_RPAREN;
			",": cc = CC_COMMA;
			"*": cc = CC_STAR;
			";": cc = CC_SEMI;
			"=": cc = CC_EQ;
			"<": cc = CC_LT;
			">": cc = CC_GT;
			"!": cc = CC_BANG;
			default: cc = CC_OTHER;
		endcase
		return cc;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= "A" && c <= "Z") begin
			r = c + 8'd32;
		end
		return r;
	endfunction

endpackage

>>> rtl/sqlt_front.sv
module sqlt_front #(
	parameter int MAX_STMT_LEN  = 4096,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       char_byte,
	input  logic             char_valid,
	input  logic             is_last,
	output logic             push_o,
	output sqlt_pkg::bundle_t bundle_o
);

	localparam int PW  = $clog2(MAX_STMT_LEN + 1);
	localparam int CW  = $clog2(KEYWORD_CHARS + 2);
	localparam int WIW = $clog2(KEYWORD_CHARS);
	localparam int XW  = (PW > sqlt_pkg::START_W) ? PW : sqlt_pkg::START_W;
	localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_STMT_LEN);
	localparam logic [CW-1:0] WC_FULL   = CW'(KEYWORD_CHARS);
	localparam logic [CW-1:0] WC_OVER   = CW'(KEYWORD_CHARS + 1);

	typedef enum logic [2:0] {
		M_IDLE, M_WORD, M_NUM, M_STR, M_LT, M_GT, M_BANG, M_ERR
	} mode_t;

	mode_t                          mode_q, mode_d;
	logic [PW-1:0]                  pos_q, pos_d;
	logic [PW-1:0]                  beg_q, beg_d;
	logic [CW-1:0]                  wcnt_q, wcnt_d;
	logic [KEYWORD_CHARS-1:0][7:0]  wchars_q, wchars_d;
	logic [PW-1:0]                  len_d;
	logic [1:0]                     n_d;
	sqlt_pkg::result_t [2:0]        res_d;
	sqlt_pkg::cclass_t              cls;
	logic                           used;

	function automatic sqlt_pkg::result_t mk_res(
		input logic [sqlt_pkg::KIND_W-1:0] kind,
		input logic [PW-1:0]               start,
		input logic [PW-1:0]               len,
		input logic [sqlt_pkg::STAT_W-1:0] status
	);
		sqlt_pkg::result_t r;
		r.kind   = kind;
		r.start  = (XW'(start) > XW'(sqlt_pkg::START_MAX)) ? sqlt_pkg::START_MAX
		                                                     : sqlt_pkg::START_W'(start);
		r.length = sqlt_pkg::LEN_W'(len);
		r.status = status;
		return r;
	endfunction

	// Matches only the characters that belong to the current word, so the
	// unwritten tail of the character store never matters.
	function automatic logic [sqlt_pkg::KIND_W-1:0] kw_kind(
		input logic [KEYWORD_CHARS-1:0][7:0] wch,
		input logic [CW-1:0]                 wc
	);
		logic [sqlt_pkg::KIND_W-1:0] k;
		logic                        hit;
		k = sqlt_pkg::TK_IDENT;
		for (int i = sqlt_pkg::KW_NUM - 1; i >= 0; i--) begin
			hit = (wc == CW'(sqlt_pkg::KW_LEN[i]));
			for (int j = 0; j < sqlt_pkg::KW_MAXLEN; j++) begin
				if (j < int'(sqlt_pkg::KW_LEN[i]) &&
				    wch[j] != sqlt_pkg::KW_TEXT[i][8*(sqlt_pkg::KW_MAXLEN-j)-1 -: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				k = sqlt_pkg::TK_KW0 + sqlt_pkg::KIND_W'(i);
			end
		end
		return k;
	endfunction

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		beg_d    = beg_q;
		wcnt_d   = wcnt_q;
		wchars_d = wchars_q;
		n_d      = 2'd0;
		res_d    = '0;
		used     = 1'b0;
		len_d    = '0;
		cls      = sqlt_pkg::classify(char_byte);

		if (char_valid && mode_d != M_ERR) begin
			if (pos_d >= POS_LIMIT) begin
				res_d[n_d] = mk_res(sqlt_pkg::TK_EOF, pos_d, '0, sqlt_pkg::ST_LONG);
				n_d        = n_d + 2'd1;
				mode_d     = M_ERR;
			end else begin
				unique case (mode_d)
					M_WORD: begin
						if (cls == sqlt_pkg::CC_ALPHA || cls == sqlt_pkg::CC_DIGIT ||
						    cls == sqlt_pkg::CC_UNDER) begin
							if (wcnt_d < WC_FULL) begin
								wchars_d[wcnt_d[WIW-1:0]] = sqlt_pkg::to_lower(char_byte);
								wcnt_d = wcnt_d + 1'b1;
							end else begin
								wcnt_d = WC_OVER;
							end
							used = 1'b1;
						end else begin
							len_d      = pos_d - beg_d;
							res_d[n_d] = mk_res(kw_kind(wchars_d, wcnt_d), beg_d, len_d,
							                    sqlt_pkg::ST_OK);
							n_d        = n_d + 2'd1;
							mode_d     = M_IDLE;
						end
					end
					M_NUM: begin
						if (cls == sqlt_pkg::CC_DIGIT) begin
							used = 1'b1;
						end else begin
							len_d      = pos_d - beg_d;
							res_d[n_d] = mk_res(sqlt_pkg::TK_INT, beg_d, len_d, sqlt_pkg::ST_OK);
							n_d        = n_d + 2'd1;
							mode_d     = M_IDLE;
						end
					end
					M_STR: begin
						if (cls == sqlt_pkg::CC_QUOTE) begin
							len_d      = pos_d - beg_d + 1'b1;
							res_d[n_d] = mk_res(sqlt_pkg::TK_STR, beg_d, len_d, sqlt_pkg::ST_OK);
							n_d        = n_d + 2'd1;
							mode_d     = M_IDLE;
						end
						used = 1'b1;
					end
					M_LT, M_GT: begin
						if (cls == sqlt_pkg::CC_EQ) begin
							res_d[n_d] = mk_res((mode_d == M_LT) ? sqlt_pkg::TK_LE : sqlt_pkg::TK_GE,
							                    beg_d, PW'(2), sqlt_pkg::ST_OK);
							used       = 1'b1;
						end else begin
							res_d[n_d] = mk_res((mode_d == M_LT) ? sqlt_pkg::TK_LT : sqlt_pkg::TK_GT,
							                    beg_d, PW'(1), sqlt_pkg::ST_OK);
						end
						n_d    = n_d + 2'd1;
						mode_d = M_IDLE;
					end
					M_BANG: begin
						if (cls == sqlt_pkg::CC_EQ) begin
							res_d[n_d] = mk_res(sqlt_pkg::TK_NE, beg_d, PW'(2), sqlt_pkg::ST_OK);
							mode_d     = M_IDLE;
						end else begin
							res_d[n_d] = mk_res(sqlt_pkg::TK_EOF, pos_d, '0, sqlt_pkg::ST_SYNTAX);
							mode_d     = M_ERR;
						end
						n_d  = n_d + 2'd1;
						used = 1'b1;
					end
					default: begin
					end
				endcase

				// A non-space character not absorbed by the pending token starts a new one.
				if (!used && mode_d == M_IDLE) begin
					beg_d = pos_d;
					unique case (cls)
						sqlt_pkg::CC_SPACE: begin
						end
						sqlt_pkg::CC_ALPHA, sqlt_pkg::CC_UNDER: begin
							mode_d      = M_WORD;
							wchars_d[0] = sqlt_pkg::to_lower(char_byte);
							wcnt_d      = CW'(1);
						end
						sqlt_pkg::CC_DIGIT: mode_d = M_NUM;
						sqlt_pkg::CC_QUOTE: mode_d = M_STR;
						sqlt_pkg::CC_LT:    mode_d = M_LT;
						sqlt_pkg::CC_GT:    mode_d = M_GT;
						sqlt_pkg::CC_BANG:  mode_d = M_BANG;
						sqlt_pkg::CC_LPAREN, sqlt_pkg::CC_RPAREN, sqlt_pkg::CC_COMMA,
						sqlt_pkg::CC_STAR, sqlt_pkg::CC_SEMI, sqlt_pkg::CC_EQ: begin
							unique case (cls)
								sqlt_pkg::CC_LPAREN: res_d[n_d].kind = sqlt_pkg::TK_LPAREN;
								sqlt_pkg::CC_RPAREN: res_d[n_d].kind = sqlt_pkg::TK_RPAREN;
								sqlt_pkg::CC_COMMA:  res_d[n_d].kind = sqlt_pkg::TK_COMMA;
								sqlt_pkg::CC_STAR:   res_d[n_d].kind = sqlt_pkg::TK_STAR;
								sqlt_pkg::CC_SEMI:   res_d[n_d].kind = sqlt_pkg::TK_SEMI;
								default:             res_d[n_d].kind = sqlt_pkg::TK_EQ;
							endcase
							res_d[n_d] = mk_res(res_d[n_d].kind, pos_d, PW'(1), sqlt_pkg::ST_OK);
							n_d        = n_d + 2'd1;
						end
						default: begin
							res_d[n_d] = mk_res(sqlt_pkg::TK_EOF, pos_d, '0, sqlt_pkg::ST_SYNTAX);
							n_d        = n_d + 2'd1;
							mode_d     = M_ERR;
						end
					endcase
				end
				pos_d = pos_d + 1'b1;
			end
		end

		if (is_last) begin
			if (mode_d == M_STR || mode_d == M_BANG) begin
				res_d[n_d] = mk_res(sqlt_pkg::TK_EOF, beg_d, '0, sqlt_pkg::ST_SYNTAX);
				n_d        = n_d + 2'd1;
			end else if (mode_d != M_ERR) begin
				len_d = pos_d - beg_d;
				unique case (mode_d)
					M_WORD: begin
						res_d[n_d] = mk_res(kw_kind(wchars_d, wcnt_d), beg_d, len_d,
						                    sqlt_pkg::ST_OK);
						n_d        = n_d + 2'd1;
					end
					M_NUM: begin
						res_d[n_d] = mk_res(sqlt_pkg::TK_INT, beg_d, len_d, sqlt_pkg::ST_OK);
						n_d        = n_d + 2'd1;
					end
					M_LT: begin
						res_d[n_d] = mk_res(sqlt_pkg::TK_LT, beg_d, PW'(1), sqlt_pkg::ST_OK);
						n_d        = n_d + 2'd1;
					end
					M_GT: begin
						res_d[n_d] = mk_res(sqlt_pkg::TK_GT, beg_d, PW'(1), sqlt_pkg::ST_OK);
						n_d        = n_d + 2'd1;
					end
					default: begin
					end
				endcase
				res_d[n_d] = mk_res(sqlt_pkg::TK_EOF, pos_d, '0, sqlt_pkg::ST_OK);
				n_d        = n_d + 2'd1;
			end
			mode_d = M_IDLE;
			pos_d  = '0;
			beg_d  = '0;
			wcnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			beg_q  <= '0;
			wcnt_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			beg_q  <= beg_d;
			wcnt_q <= wcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wchars_q <= wchars_d;
		end
	end

	assign push_o       = accept && (n_d != 2'd0);
	assign bundle_o.n   = n_d;
	assign bundle_o.res = res_d;

`include "sql_token_lexer_assert.svh"

	`SQLT_ASSERT_IMP(a_pos_range, clk, arst_n, 1'b1, pos_q <= POS_LIMIT)
	`SQLT_ASSERT_IMP(a_err_silent, clk, arst_n, accept && mode_q == M_ERR && !is_last, !push_o)

endmodule

>>> rtl/sqlt_fifo.sv
module sqlt_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sqlt_pkg::bundle_t wr_data,
	output logic              full,
	input  logic              pop,
	output sqlt_pkg::bundle_t rd_data,
	output logic              empty
);

	sqlt_pkg::bundle_t                 mem_q [sqlt_pkg::QDEPTH];
	logic [sqlt_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [sqlt_pkg::QCNT_W-1:0]       count_q;
	logic                              do_push, do_pop;

	assign full    = (count_q == sqlt_pkg::QCNT_W'(sqlt_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

`include "sql_token_lexer_assert.svh"

	`SQLT_ASSERT_NEXT(a_cnt_up, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + 1'b1)

endmodule

>>> rtl/sqlt_back.sv
module sqlt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sqlt_pkg::bundle_t head,
	input  logic              q_empty,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output sqlt_pkg::result_t res_o,
	output logic              last_o
);

	logic [1:0] idx_q;
	logic       take;

	assign empty  = q_empty;
	assign take   = pop && !q_empty;
	assign res_o  = head.res[idx_q];
	assign last_o = (idx_q == head.n - 2'd1);
	// The item's slot in the queue is freed once its final result is taken.
	assign q_pop  = take && last_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
		end
	end

`include "sql_token_lexer_assert.svh"

	`SQLT_ASSERT_IMP(a_head_nonempty, clk, arst_n, !q_empty, head.n != 2'd0)
	`SQLT_ASSERT_IMP(a_idx_inside, clk, arst_n, !q_empty, idx_q < head.n)

endmodule

>>> rtl/sql_token_lexer.sv
// Character-serial SQL lexer. One character item is accepted per clock while full is low;
// the lexer state is updated in that cycle and the tokens it completes (up to three:
// a pending token, a one-character token or error, and the end token) are written
// as one entry into a four-entry queue. The result side drains that queue one token
// per clock while pop is high; an item's results reach the ports once its queue entry
// is written and the entries ahead of it are drained, its tokens popped one at a time.
// Sustained input rate is one item per clock as long as pop stays high and items average
// at most one token each; full rises only when four items' tokens are waiting.
module sql_token_lexer #(
	parameter int MAX_STMT_LEN  = 4096,
	parameter int KEYWORD_CHARS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_byte,
	input  logic        char_valid,
	input  logic        is_last,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  token_kind,
	output logic [11:0] token_start,
	output logic [12:0] token_length,
	output logic [1:0]  status,
	output logic        last_of_item
);

	logic              accept;
	logic              f_push;
	sqlt_pkg::bundle_t f_bundle;
	sqlt_pkg::bundle_t q_head;
	logic              q_empty;
	logic              q_pop;
	sqlt_pkg::result_t res;

	assign accept = push && !full;

	sqlt_front #(
		.MAX_STMT_LEN  (MAX_STMT_LEN),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_byte  (char_byte),
		.char_valid (char_valid),
		.is_last    (is_last),
		.push_o     (f_push),
		.bundle_o   (f_bundle)
	);

	sqlt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_data (f_bundle),
		.full    (full),
		.pop     (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	sqlt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res_o   (res),
		.last_o  (last_of_item)
	);

	assign token_kind   = res.kind;
	assign token_start  = res.start;
	assign token_length = res.length;
	assign status       = res.status;

endmodule
